/* hdl/sbrm_pkg.sv */
// Shared widths, reset values and constants for the stereo block RMS meter.
package sbrm_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 47;
   localparam int FRAMES_W = 16;
   localparam int RMS_W    = 16;
   localparam int PCT_W    = 7;
   localparam int SQ_W     = 31;
   localparam int ROOT_IT  = 16;

   localparam logic [FRAMES_W-1:0] BLOCK_FRAMES_RST = 16'd4410;
   localparam logic [PCT_W-1:0]    PCT_MAX          = 7'd100;

endpackage

/* hdl/sbrm_req_if.sv */
// Input channel: one stereo frame per transaction.
interface sbrm_req_if
   import sbrm_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_sample;
   logic signed [SAMPLE_W-1:0] right_sample;

   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

/* hdl/sbrm_rsp_if.sv */
// Result channel: one meter reading per transaction.
interface sbrm_rsp_if
   import sbrm_pkg::*;
();
   logic             valid;
   logic             ready;
   logic [RMS_W-1:0] rms_left;
   logic [RMS_W-1:0] rms_right;
   logic [PCT_W-1:0] percent_left;
   logic [PCT_W-1:0] percent_right;

   modport source (output valid, output rms_left, output rms_right,
                   output percent_left, output percent_right, input ready);
   modport sink   (input valid, input rms_left, input rms_right,
                   input percent_left, input percent_right, output ready);
endinterface

/* hdl/stereo_block_rms_meter.sv */
// Stereo block RMS meter: square-and-sum per frame, divide, root and percent per block.
// A frame that does not close a block is squared and summed (left, right, accumulate states),
// then ready rises again. A block-closing frame goes on, per channel, through 47 divide steps,
// 16 root steps and a percent step; the reading then goes to the output register once it is free.
// Frames are taken only while the sequencer idles, so a new frame waits until the last is through;
// the shared subtract/compare unit serves both the divide and the root steps.
// Reset (synchronous, active high): sums and frame count zero, block_frames 4410, no reading.
module stereo_block_rms_meter
   import sbrm_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   sbrm_req_if.sink            req_bus,
   sbrm_rsp_if.source          rsp_bus,
   input  logic                csr_wr_en,
   input  logic [FRAMES_W-1:0] csr_wr_data
);

   // width of the shared subtract/compare unit; covers {rem,2 bits} of the root steps
   localparam int UW     = 20;
   localparam int STEP_W = $clog2(SUM_W);

   // sequencer codes
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQ_L = 3'd1;  // left square into product register
   localparam logic [2:0] ST_SQ_R = 3'd2;  // add left square, right square
   localparam logic [2:0] ST_ACC  = 3'd3;  // add right square, test block end
   localparam logic [2:0] ST_DIV  = 3'd4;  // one restoring divide step per cycle
   localparam logic [2:0] ST_SQRT = 3'd5;  // one root digit per cycle
   localparam logic [2:0] ST_PCT  = 3'd6;  // percent of full scale, next channel
   localparam logic [2:0] ST_DONE = 3'd7;  // hand reading to the output register

   // control state
   logic [2:0]          state_ff, state_in;
   logic [SUM_W-1:0]    sum_l_ff, sum_l_in;
   logic [SUM_W-1:0]    sum_r_ff, sum_r_in;
   logic [FRAMES_W-1:0] frames_ff, frames_in;
   logic [FRAMES_W-1:0] blk_ff, blk_in;
   logic                ch_ff, ch_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // datapath registers
   logic signed [SAMPLE_W-1:0] smp_l_ff, smp_l_in;
   logic signed [SAMPLE_W-1:0] smp_r_ff, smp_r_in;
   logic [SQ_W-1:0]            prod_ff, prod_in;
   logic [SUM_W-1:0]           wk_ff, wk_in;     // dividend/quotient, then radicand
   logic [FRAMES_W-1:0]        div_ff, div_in;
   logic [UW-1:0]              rem_ff, rem_in;
   logic [RMS_W-1:0]           root_ff, root_in;
   logic [RMS_W-1:0]           res_rms_l_ff, res_rms_l_in;
   logic [PCT_W-1:0]           res_pct_l_ff, res_pct_l_in;
   logic [RMS_W-1:0]           res_rms_r_ff, res_rms_r_in;
   logic [PCT_W-1:0]           res_pct_r_ff, res_pct_r_in;
   logic [RMS_W-1:0]           out_rms_l_ff, out_rms_l_in;
   logic [RMS_W-1:0]           out_rms_r_ff, out_rms_r_in;
   logic [PCT_W-1:0]           out_pct_l_ff, out_pct_l_in;
   logic [PCT_W-1:0]           out_pct_r_ff, out_pct_r_in;

   // shared multiplier: squares one sample per cycle
   logic signed [SAMPLE_W-1:0]   mul_op;
   logic signed [2*SAMPLE_W-1:0] sq_full;

   // shared subtract/compare unit used by divide and root steps
   logic [UW-1:0] unit_a, unit_b;
   logic [UW:0]   unit_diff;
   logic          unit_ge;

   // percent: root*100 by shifts and adds, then divide by 32768
   logic [RMS_W+6:0] pct_scaled;
   logic [7:0]       pct_raw;
   logic [PCT_W-1:0] pct_val;

   logic [FRAMES_W:0] count_next;
   logic [FRAMES_W:0] limit;
   logic              req_take;
   logic              rsp_free;

   assign req_take = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   assign mul_op  = (state_ff == ST_SQ_L) ? smp_l_ff : smp_r_ff;
   assign sq_full = mul_op * mul_op;

   always_comb begin
      case (state_ff)
         ST_DIV: begin
            unit_a = {3'b000, rem_ff[FRAMES_W-1:0], wk_ff[SUM_W-1]};
            unit_b = {4'b0000, div_ff};
         end
         ST_SQRT: begin
            unit_a = {rem_ff[UW-3:0], wk_ff[31:30]};
            unit_b = {2'b00, root_ff, 2'b01};
         end
         default: begin
            unit_a = '0;
            unit_b = '0;
         end
      endcase
   end

   assign unit_diff = {1'b0, unit_a} - {1'b0, unit_b};
   assign unit_ge   = !unit_diff[UW];

   assign pct_scaled = {1'b0, root_ff, 6'b0} + {2'b0, root_ff, 5'b0} + {5'b0, root_ff, 2'b0};
   assign pct_raw    = pct_scaled[RMS_W+6:RMS_W-1];
   assign pct_val    = (pct_raw > {1'b0, PCT_MAX}) ? PCT_MAX : pct_raw[PCT_W-1:0];

   // block_frames of zero behaves as one
   assign count_next = {1'b0, frames_ff} + 1'b1;
   assign limit      = (blk_ff == '0) ? 17'd1 : {1'b0, blk_ff};

   always_comb begin
      state_in     = state_ff;
      sum_l_in     = sum_l_ff;
      sum_r_in     = sum_r_ff;
      frames_in    = frames_ff;
      blk_in       = blk_ff;
      ch_in        = ch_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      smp_l_in     = smp_l_ff;
      smp_r_in     = smp_r_ff;
      prod_in      = prod_ff;
      wk_in        = wk_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      res_rms_l_in = res_rms_l_ff;
      res_pct_l_in = res_pct_l_ff;
      res_rms_r_in = res_rms_r_ff;
      res_pct_r_in = res_pct_r_ff;
      out_rms_l_in = out_rms_l_ff;
      out_rms_r_in = out_rms_r_ff;
      out_pct_l_in = out_pct_l_ff;
      out_pct_r_in = out_pct_r_ff;

      if (csr_wr_en) begin
         blk_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               smp_l_in = req_bus.left_sample;
               smp_r_in = req_bus.right_sample;
               state_in = ST_SQ_L;
            end
         end
         ST_SQ_L: begin
            prod_in  = sq_full[SQ_W-1:0];
            state_in = ST_SQ_R;
         end
         ST_SQ_R: begin
            sum_l_in = sum_l_ff + {{(SUM_W-SQ_W){1'b0}}, prod_ff};
            prod_in  = sq_full[SQ_W-1:0];
            state_in = ST_ACC;
         end
         ST_ACC: begin
            sum_r_in = sum_r_ff + {{(SUM_W-SQ_W){1'b0}}, prod_ff};
            if (count_next < limit) begin
               frames_in = count_next[FRAMES_W-1:0];
               state_in  = ST_IDLE;
            end else begin
               div_in   = count_next[FRAMES_W-1:0];
               wk_in    = sum_l_ff;
               rem_in   = '0;
               step_in  = '0;
               ch_in    = 1'b0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = unit_ge ? unit_diff[UW-1:0] : unit_a;
            wk_in   = {wk_ff[SUM_W-2:0], unit_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(SUM_W-1)) begin
               step_in  = '0;
               rem_in   = '0;
               root_in  = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            rem_in  = unit_ge ? unit_diff[UW-1:0] : unit_a;
            root_in = {root_ff[RMS_W-2:0], unit_ge};
            wk_in   = {wk_ff[SUM_W-3:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_IT-1)) begin
               step_in  = '0;
               state_in = ST_PCT;
            end
         end
         ST_PCT: begin
            if (!ch_ff) begin
               res_rms_l_in = root_ff;
               res_pct_l_in = pct_val;
               ch_in        = 1'b1;
               wk_in        = sum_r_ff;
               rem_in       = '0;
               step_in      = '0;
               state_in     = ST_DIV;
            end else begin
               res_rms_r_in = root_ff;
               res_pct_r_in = pct_val;
               state_in     = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               out_rms_l_in = res_rms_l_ff;
               out_rms_r_in = res_rms_r_ff;
               out_pct_l_in = res_pct_l_ff;
               out_pct_r_in = res_pct_r_ff;
               sum_l_in     = '0;
               sum_r_in     = '0;
               frames_in    = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_l_ff     <= '0;
         sum_r_ff     <= '0;
         frames_ff    <= '0;
         blk_ff       <= BLOCK_FRAMES_RST;
         ch_ff        <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_l_ff     <= sum_l_in;
         sum_r_ff     <= sum_r_in;
         frames_ff    <= frames_in;
         blk_ff       <= blk_in;
         ch_ff        <= ch_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers, no reset needed
   always_ff @(posedge clock) begin
      smp_l_ff     <= smp_l_in;
      smp_r_ff     <= smp_r_in;
      prod_ff      <= prod_in;
      wk_ff        <= wk_in;
      div_ff       <= div_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      res_rms_l_ff <= res_rms_l_in;
      res_pct_l_ff <= res_pct_l_in;
      res_rms_r_ff <= res_rms_r_in;
      res_pct_r_ff <= res_pct_r_in;
      out_rms_l_ff <= out_rms_l_in;
      out_rms_r_ff <= out_rms_r_in;
      out_pct_l_ff <= out_pct_l_in;
      out_pct_r_ff <= out_pct_r_in;
   end

   // frames are taken only while the sequencer idles; the output register is separate
   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.rms_left      = out_rms_l_ff;
   assign rsp_bus.rms_right     = out_rms_r_ff;
   assign rsp_bus.percent_left  = out_pct_l_ff;
   assign rsp_bus.percent_right = out_pct_r_ff;

   // a reading is only raised from the hand-over state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("reading raised outside hand-over");

   // an accepted frame always starts the squaring sequence
   a_take_starts: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_SQ_L))
      else $error("accepted frame did not start squaring");

   // root stage never runs past its digit count
   a_root_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT) |-> (step_ff < STEP_W'(ROOT_IT)))
      else $error("root step counter overran");

   // percent readings stay within full scale
   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((out_pct_l_ff <= PCT_MAX) && (out_pct_r_ff <= PCT_MAX)))
      else $error("percent reading above full scale");

endmodule

/* tb/tb_stereo_block_rms_meter.sv */
// Self-checking testbench for the stereo block RMS meter: random frames, block lengths and back-pressure.
`timescale 1ns / 100ps

module tb_stereo_block_rms_meter;
   import sbrm_pkg::*;

   // Run limits: the first three in clock cycles, the last two in frames
   localparam int CYCLE_LIMIT     = 1_500_000; // watchdog, well above the slowest correct run
   localparam int DRAIN_CYCLES    = 150;       // lets a block-closing frame run through
   localparam int HOLD_OFF_CYCLES = 600;       // long receiver stall to fill the block up
   localparam int FRAME_TARGET    = 1650;
   localparam int TAIL_FRAMES     = 150;       // closing stretch with no idling

   // One meter reading as it leaves the block
   typedef struct packed {
      logic [RMS_W-1:0] rms_left;
      logic [RMS_W-1:0] rms_right;
      logic [PCT_W-1:0] percent_left;
      logic [PCT_W-1:0] percent_right;
   } reading_type;

   // Predicts readings from accepted frames and checks what comes out
   class meter_scoreboard;
      logic [FRAMES_W-1:0] block_len;
      logic [SUM_W-1:0]    left_energy;
      logic [SUM_W-1:0]    right_energy;
      logic [FRAMES_W-1:0] frames_in_block;
      reading_type         expected_readings[$];
      int                  mismatches;

      function new();
         block_len       = BLOCK_FRAMES_RST;
         left_energy     = '0;
         right_energy    = '0;
         frames_in_block = '0;
         mismatches      = 0;
      endfunction

      function void set_block_frames(logic [FRAMES_W-1:0] value);
         block_len = value;
      endfunction

      function int pending();
         return expected_readings.size();
      endfunction

      // Greedy bit-by-bit floor root; the mean is at most 2^30, so the root fits 16 bits
      static function logic [RMS_W-1:0] floor_root(logic [SUM_W-1:0] x);
         logic [16:0] root;
         logic [16:0] trial;
         root = '0;
         for (int b = 16; b >= 0; b--) begin
            trial = root | (17'd1 << b);
            if (64'(trial) * 64'(trial) <= 64'(x))
               root = trial;
         end
         return root[RMS_W-1:0];
      endfunction

      static function logic [PCT_W-1:0] level_percent(logic [RMS_W-1:0] rms);
         logic [31:0] scaled;
         scaled = (32'(rms) * 32'd100) >> 15;
         return (scaled > 32'(PCT_MAX)) ? PCT_MAX : scaled[PCT_W-1:0];
      endfunction

      function void note_frame(logic signed [SAMPLE_W-1:0] left, logic signed [SAMPLE_W-1:0] right);
         longint      l_sq;
         longint      r_sq;
         logic [16:0] count;
         logic [16:0] limit;
         reading_type r;
         l_sq = longint'(left) * longint'(left);
         r_sq = longint'(right) * longint'(right);
         left_energy  = left_energy + l_sq[SUM_W-1:0];
         right_energy = right_energy + r_sq[SUM_W-1:0];
         count = 17'(frames_in_block) + 17'd1;
         // a zero length behaves as one; a length lowered mid-block closes on reaching or passing it
         limit = (block_len == '0) ? 17'd1 : 17'(block_len);
         if (count < limit) begin
            frames_in_block = count[FRAMES_W-1:0];
            return;
         end
         r.rms_left      = floor_root(SUM_W'(left_energy / SUM_W'(count)));
         r.rms_right     = floor_root(SUM_W'(right_energy / SUM_W'(count)));
         r.percent_left  = level_percent(r.rms_left);
         r.percent_right = level_percent(r.rms_right);
         expected_readings.push_back(r);
         left_energy     = '0;
         right_energy    = '0;
         frames_in_block = '0;
      endfunction

      function void check_reading(reading_type got);
         reading_type exp_r;
         if (expected_readings.size() == 0) begin
            $error("reading with none expected: rms %0d/%0d, percent %0d/%0d",
                   got.rms_left, got.rms_right, got.percent_left, got.percent_right);
            mismatches++;
            return;
         end
         exp_r = expected_readings.pop_front();
         if (got.rms_left !== exp_r.rms_left) begin
            $error("rms_left: expected %0d, actual %0d", exp_r.rms_left, got.rms_left);
            mismatches++;
         end
         if (got.rms_right !== exp_r.rms_right) begin
            $error("rms_right: expected %0d, actual %0d", exp_r.rms_right, got.rms_right);
            mismatches++;
         end
         if (got.percent_left !== exp_r.percent_left) begin
            $error("percent_left: expected %0d, actual %0d", exp_r.percent_left, got.percent_left);
            mismatches++;
         end
         if (got.percent_right !== exp_r.percent_right) begin
            $error("percent_right: expected %0d, actual %0d", exp_r.percent_right,
                   got.percent_right);
            mismatches++;
         end
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [FRAMES_W-1:0] csr_wr_data;

   sbrm_req_if req_chan ();
   sbrm_rsp_if rsp_chan ();

   meter_scoreboard sb = new();

   // Knobs shared between the stimulus and the receiver
   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   bit          quiet_tail;
   bit          hold_off_req;
   int          frames_sent;
   int          cycle_count;

   stereo_block_rms_meter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_chan),
      .rsp_bus     (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 8 ns clock
   initial clock = 1'b0;
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a lost reading ends the run here
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[stereo_block_rms_meter] ERROR");
      $finish;
   end

   // Monitor: both channels are sampled at the edge, before any update of that edge lands.
   // A reading can never stem from a frame taken at the same edge, so the order is immaterial.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready)
            sb.note_frame(req_chan.left_sample, req_chan.right_sample);
         if (rsp_chan.valid && rsp_chan.ready)
            sb.check_reading(reading_type'{rsp_chan.rms_left, rsp_chan.rms_right,
                                           rsp_chan.percent_left, rsp_chan.percent_right});
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request.
   // The hold-off is timed here so the sender keeps pushing frames meanwhile.
   initial begin
      int held;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_chan.ready <= 1'b0;
            held = 0;
            while (held < HOLD_OFF_CYCLES) begin
               @(posedge clock);
               held++;
            end
            hold_off_req = 1'b0;
            rsp_chan.ready <= 1'b1;
         end else if (!quiet_tail && $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   // Offer one frame and hold it until taken; then maybe leave a gap.
   // Valid stays high between back-to-back frames, so it is never lowered and raised in one step.
   task automatic send_frame(logic signed [SAMPLE_W-1:0] left, logic signed [SAMPLE_W-1:0] right);
      req_chan.valid        <= 1'b1;
      req_chan.left_sample  <= left;
      req_chan.right_sample <= right;
      do @(posedge clock); while (!req_chan.ready);
      frames_sent++;
      if (!quiet_tail && $urandom_range(0, 99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   // Lower valid, wait for all readings, then let a partial frame settle before touching the CSR
   task automatic wait_meter_idle();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_block_frames(logic [FRAMES_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      sb.set_block_frames(value);
      csr_wr_en   <= 1'b0;
   endtask

   // Mix of full-scale, near-zero, near-full-scale and uniform samples
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      logic signed [SAMPLE_W-1:0] s;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: s = 16'sh7FFF;
               1: s = 16'sh8000;
               2: s = '0;
               default: s = -16'sd1;
            endcase
         end
         1, 2: s = SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
         3: s = $urandom_range(0, 1) ? SAMPLE_W'($urandom_range(32000, 32767))
                                     : SAMPLE_W'(-$signed($urandom_range(32000, 32768)));
         default: s = SAMPLE_W'($urandom);
      endcase
      return s;
   endfunction

   function automatic logic [FRAMES_W-1:0] pick_block_len();
      logic [FRAMES_W-1:0] n;
      case ($urandom_range(0, 19))
         0: n = '0;
         1: n = 16'hFFFF;   // long block: the phase leaves it partial, the next one cuts it short
         2, 3: n = FRAMES_W'($urandom_range(9, 64));
         default: n = FRAMES_W'($urandom_range(1, 8));
      endcase
      return n;
   endfunction

   function automatic int unsigned pick_idle_pct();
      int unsigned p;
      case ($urandom_range(0, 3))
         0: p = 0;
         1: p = 5;
         2: p = 20;
         default: p = 50;
      endcase
      return p;
   endfunction

   initial begin
      int n_frames;
      reset                 = 1'b1;
      csr_wr_en             = 1'b0;
      csr_wr_data           = '0;
      req_chan.valid        = 1'b0;
      req_chan.left_sample  = '0;
      req_chan.right_sample = '0;
      req_idle_pct          = 0;
      rsp_idle_pct          = 0;
      quiet_tail            = 1'b0;
      hold_off_req          = 1'b0;
      frames_sent           = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- Directed part ---
      // Reset length (4410): a few frames give nothing; then a shorter length closes the block
      send_frame(16'sh7FFF, 16'sh8000);
      send_frame(16'sd3, -16'sd3);
      send_frame(16'sh8000, 16'sd0);
      send_frame(-16'sd1, 16'sh7FFF);
      wait_meter_idle();
      write_block_frames(16'd2);
      send_frame(16'sd100, -16'sd100);   // count passes the new length: mean over five frames
      wait_meter_idle();

      // One frame per reading: extremes of both channels
      write_block_frames(16'd1);
      send_frame(16'sd0, 16'sd0);
      send_frame(16'sh7FFF, 16'sh8000);
      send_frame(16'sh8000, 16'sh7FFF);
      send_frame(16'sh8000, 16'sh8000);   // full-scale negative: rms 32768, percent exactly 100
      send_frame(-16'sd1, 16'sd1);
      send_frame(16'sh5555, 16'shAAAA);
      wait_meter_idle();

      // Zero length acts as one
      write_block_frames(16'd0);
      send_frame(16'sh7FFF, -16'sd2);
      send_frame(16'sd181, 16'sh8000);
      wait_meter_idle();

      // Longest block, then cut short mid-block
      write_block_frames(16'hFFFF);
      repeat (5) send_frame(16'sh8000, 16'sh7FFF);
      wait_meter_idle();
      write_block_frames(16'd3);
      send_frame(16'sh8000, 16'sh8000);
      wait_meter_idle();

      // --- Back-pressure: one-frame blocks while the receiver holds off ---
      write_block_frames(16'd1);
      req_idle_pct = 0;
      hold_off_req = 1'b1;
      repeat (40) send_frame(pick_sample(), pick_sample());
      wait_meter_idle();

      // --- Random phases: new length, idling and frame count per phase ---
      while (frames_sent < FRAME_TARGET - TAIL_FRAMES) begin
         write_block_frames(pick_block_len());
         req_idle_pct = pick_idle_pct();
         rsp_idle_pct = pick_idle_pct();
         n_frames = $urandom_range(10, 60);
         repeat (n_frames) send_frame(pick_sample(), pick_sample());
         wait_meter_idle();
      end

      // --- Closing stretch, no idling on either side ---
      quiet_tail = 1'b1;
      write_block_frames(FRAMES_W'($urandom_range(1, 4)));
      repeat (TAIL_FRAMES) send_frame(pick_sample(), pick_sample());
      wait_meter_idle();

      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("[stereo_block_rms_meter] OK");
      else
         $display("[stereo_block_rms_meter] ERROR");
      $finish;
   end

endmodule

/* stereo_block_rms_meter.f */
hdl/sbrm_pkg.sv
hdl/sbrm_req_if.sv
hdl/sbrm_rsp_if.sv
hdl/stereo_block_rms_meter.sv
tb/tb_stereo_block_rms_meter.sv
